// ===== rtl/core/kpl_pkg.sv =====
// kpl_pkg: types, codes and reset constants shared by the keypad passcode lock
// used by kpl_ctrl, kpl_datapath, keypad_passcode_lock and kpl_checker
// no dependencies
package kpl_pkg;

  // field widths
  localparam int TONE_W  = 15;
  localparam int TIMER_W = 16;

  // lock modes, also the mode field code of a result word
  typedef enum logic [2:0] {
    MODE_LOCKED   = 3'd0,
    MODE_WARNING  = 3'd1,
    MODE_UNLOCKED = 3'd2,
    MODE_CHANGE   = 3'd3,
    MODE_CHFAIL   = 3'd4,
    MODE_CHOK     = 3'd5
  } mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LOCKOUT       = 3'd0,
    REG_START_TONE    = 3'd1,
    REG_WARNING_TONE  = 3'd2,
    REG_UNLOCKED_TONE = 3'd3,
    REG_SUCCESS_TONE  = 3'd4
  } cfg_reg_t;

  // buzzer frequency selection
  typedef enum logic [1:0] {
    TONE_KEEP     = 2'd0,
    TONE_WARNING  = 2'd1,
    TONE_UNLOCKED = 2'd2,
    TONE_SUCCESS  = 2'd3
  } tone_sel_t;

  // mode timer operations
  typedef enum logic [1:0] {
    TIMER_HOLD    = 2'd0,
    TIMER_CLEAR   = 2'd1,
    TIMER_INC     = 2'd2,
    TIMER_RESTART = 2'd3
  } timer_op_t;

  // led codes
  localparam logic [1:0] LED_OFF  = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_SLOW = 2'd2;
  localparam logic [1:0] LED_FAST = 2'd3;

  // message codes
  localparam logic [2:0] MSG_ENTER    = 3'd0;
  localparam logic [2:0] MSG_WRONG    = 3'd1;
  localparam logic [2:0] MSG_UNLOCKED = 3'd2;
  localparam logic [2:0] MSG_SET_NEW  = 3'd3;
  localparam logic [2:0] MSG_CHFAIL   = 3'd4;
  localparam logic [2:0] MSG_CHOK     = 3'd5;

  // digit code that means no key; also marks an empty entry slot
  localparam logic [1:0] DIGIT_NONE = 2'd3;

  // register reset values
  localparam logic [TIMER_W-1:0] LOCKOUT_RESET       = 16'd1500;
  localparam logic [TONE_W-1:0]  START_TONE_RESET    = 15'd200;
  localparam logic [TONE_W-1:0]  WARNING_TONE_RESET  = 15'd50;
  localparam logic [TONE_W-1:0]  UNLOCKED_TONE_RESET = 15'd1000;
  localparam logic [TONE_W-1:0]  SUCCESS_TONE_RESET  = 15'd500;
  localparam int                 RESET_CODE_LEN      = 5;

  // factory code 1,2,0,1,1 then zeros
  function automatic logic [1:0] reset_digit(input int idx);
    logic [1:0] d;
    case (idx)
      0:       d = 2'd1;
      1:       d = 2'd2;
      3:       d = 2'd1;
      4:       d = 2'd1;
      default: d = 2'd0;
    endcase
    return d;
  endfunction

  // decoded key events of one tick
  typedef struct packed {
    logic       digit;
    logic [1:0] dval;
    logic       enter;
    logic       hold;
  } tick_t;

  // controller to datapath commands
  typedef struct packed {
    logic      entry_write;
    logic      entry_count_clr;
    logic      entry_clear_all;
    logic      new_write;
    logic      new_count_clr;
    logic      new_zero;
    logic      install;
    timer_op_t timer_op;
    tone_sel_t tone_sel;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic match;
    logic over;
    logic new_bad;
    logic timer_zero;
    logic timer_done;
  } dp_sts_t;

  // indicator outputs
  typedef struct packed {
    logic       buz;
    logic [1:0] red;
    logic [1:0] green;
    logic       blue;
    logic [2:0] message;
  } ind_t;

endpackage

// ===== rtl/core/kpl_ctrl.sv =====
// kpl_ctrl: lock mode state machine and indicator registers
// depends on kpl_pkg; drives kpl_datapath through dp_cmd_t
module kpl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  kpl_pkg::tick_t  tick,
  input  kpl_pkg::dp_sts_t sts,
  output kpl_pkg::dp_cmd_t cmd,
  output kpl_pkg::mode_t  mode_next,
  output kpl_pkg::ind_t   ind_next
);

  kpl_pkg::mode_t mode;
  kpl_pkg::ind_t  ind;

  // next mode
  always_comb begin
    mode_next = mode;
    if (step) begin
      case (mode)
        kpl_pkg::MODE_LOCKED: begin
          if (tick.hold) begin
            mode_next = kpl_pkg::MODE_CHANGE;
          end else if (tick.enter) begin
            mode_next = sts.match ? kpl_pkg::MODE_UNLOCKED : kpl_pkg::MODE_WARNING;
          end else if (sts.over) begin
            mode_next = kpl_pkg::MODE_WARNING;
          end
        end
        kpl_pkg::MODE_WARNING, kpl_pkg::MODE_CHFAIL: begin
          if (sts.timer_done) begin
            mode_next = kpl_pkg::MODE_LOCKED;
          end
        end
        kpl_pkg::MODE_UNLOCKED: begin
          if (tick.digit || tick.enter) begin
            mode_next = kpl_pkg::MODE_LOCKED;
          end
        end
        kpl_pkg::MODE_CHANGE: begin
          if (tick.enter) begin
            mode_next = sts.new_bad ? kpl_pkg::MODE_CHFAIL : kpl_pkg::MODE_CHOK;
          end
        end
        default: begin
          if (sts.timer_done) begin
            mode_next = kpl_pkg::MODE_LOCKED;
          end
        end
      endcase
    end
  end

  // commands and indicator updates, applied in key priority order
  always_comb begin
    cmd          = '0;
    cmd.timer_op = kpl_pkg::TIMER_HOLD;
    cmd.tone_sel = kpl_pkg::TONE_KEEP;
    ind_next     = ind;
    if (step) begin
      case (mode)
        kpl_pkg::MODE_LOCKED: begin
          cmd.timer_op    = kpl_pkg::TIMER_CLEAR;
          cmd.entry_write = tick.digit;
          ind_next.green  = kpl_pkg::LED_OFF;
          ind_next.red    = kpl_pkg::LED_ON;
          if (tick.enter) begin
            cmd.entry_count_clr = 1'b1;
            if (sts.match) begin
              cmd.tone_sel     = kpl_pkg::TONE_UNLOCKED;
              ind_next.buz     = 1'b1;
              ind_next.message = kpl_pkg::MSG_UNLOCKED;
              ind_next.green   = kpl_pkg::LED_SLOW;
            end else begin
              ind_next.buz     = 1'b1;
              ind_next.message = kpl_pkg::MSG_WRONG;
              ind_next.red     = kpl_pkg::LED_FAST;
            end
          end else if (sts.over) begin
            ind_next.buz     = 1'b1;
            ind_next.message = kpl_pkg::MSG_WRONG;
            ind_next.red     = kpl_pkg::LED_FAST;
          end
          // hold overrides entry, message and leds, not buzzer or tone
          if (tick.hold) begin
            cmd.entry_count_clr = 1'b1;
            cmd.new_count_clr   = 1'b1;
            cmd.entry_clear_all = 1'b1;
            ind_next.message    = kpl_pkg::MSG_SET_NEW;
            ind_next.red        = kpl_pkg::LED_SLOW;
            ind_next.green      = kpl_pkg::LED_SLOW;
          end
        end
        kpl_pkg::MODE_WARNING: begin
          cmd.entry_count_clr = 1'b1;
          cmd.entry_clear_all = sts.timer_zero;
          cmd.timer_op = sts.timer_done ? kpl_pkg::TIMER_RESTART : kpl_pkg::TIMER_INC;
          if (sts.timer_done) begin
            ind_next.red     = kpl_pkg::LED_OFF;
            ind_next.buz     = 1'b0;
            ind_next.message = kpl_pkg::MSG_ENTER;
          end
        end
        kpl_pkg::MODE_UNLOCKED: begin
          ind_next.red = kpl_pkg::LED_OFF;
          if (tick.digit || tick.enter) begin
            cmd.entry_clear_all = 1'b1;
            cmd.entry_count_clr = 1'b1;
            cmd.tone_sel        = kpl_pkg::TONE_WARNING;
            ind_next.buz        = 1'b0;
            ind_next.message    = kpl_pkg::MSG_ENTER;
            ind_next.green      = kpl_pkg::LED_OFF;
          end
        end
        kpl_pkg::MODE_CHANGE: begin
          cmd.new_write = tick.digit;
          if (tick.enter) begin
            ind_next.buz   = 1'b1;
            ind_next.green = kpl_pkg::LED_OFF;
            if (sts.new_bad) begin
              ind_next.message = kpl_pkg::MSG_CHFAIL;
              ind_next.red     = kpl_pkg::LED_FAST;
            end else begin
              cmd.tone_sel     = kpl_pkg::TONE_SUCCESS;
              ind_next.message = kpl_pkg::MSG_CHOK;
              ind_next.red     = kpl_pkg::LED_OFF;
              ind_next.blue    = 1'b1;
            end
          end
        end
        kpl_pkg::MODE_CHFAIL: begin
          cmd.entry_count_clr = 1'b1;
          cmd.new_count_clr   = 1'b1;
          cmd.new_zero        = sts.timer_zero;
          cmd.timer_op = sts.timer_done ? kpl_pkg::TIMER_RESTART : kpl_pkg::TIMER_INC;
          if (sts.timer_done) begin
            ind_next.red     = kpl_pkg::LED_OFF;
            ind_next.buz     = 1'b0;
            ind_next.message = kpl_pkg::MSG_ENTER;
          end
        end
        default: begin
          // change accepted: install the new code once the lockout runs out
          cmd.timer_op = kpl_pkg::TIMER_INC;
          if (sts.timer_done) begin
            cmd.install       = 1'b1;
            cmd.new_count_clr = 1'b1;
            cmd.tone_sel      = kpl_pkg::TONE_WARNING;
            ind_next.buz      = 1'b0;
            ind_next.message  = kpl_pkg::MSG_ENTER;
            ind_next.blue     = 1'b0;
          end
        end
      endcase
    end
  end

  // state and indicator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= kpl_pkg::MODE_LOCKED;
      ind.buz       <= 1'b0;
      ind.red       <= kpl_pkg::LED_ON;
      ind.green     <= kpl_pkg::LED_OFF;
      ind.blue      <= 1'b0;
      ind.message   <= kpl_pkg::MSG_ENTER;
    end else begin
      mode <= mode_next;
      ind  <= ind_next;
    end
  end

endmodule

// ===== rtl/core/kpl_datapath.sv =====
// kpl_datapath: entry and new-code stores, stored code, mode timer, buzzer tone
// and configuration registers; depends on kpl_pkg, commanded by kpl_ctrl
module kpl_datapath #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kpl_pkg::tick_t              tick,
  input  kpl_pkg::dp_cmd_t            cmd,
  output kpl_pkg::dp_sts_t            sts,
  output logic [kpl_pkg::TONE_W-1:0]  tone_next,
  input  logic                        cfg_valid,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  // counts reach MAX_DIGITS+1, code length at most MAX_DIGITS
  localparam int CW = $clog2(MAX_DIGITS + 2);
  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam int CODE_LEN_RESET =
    (kpl_pkg::RESET_CODE_LEN < MAX_DIGITS) ? kpl_pkg::RESET_CODE_LEN : MAX_DIGITS;

  logic [1:0]                   entry_digits [MAX_DIGITS];
  logic [CW-1:0]                entry_count;
  logic [1:0]                   new_digits [MAX_DIGITS];
  logic [CW-1:0]                new_count;
  logic [1:0]                   stored_code [MAX_DIGITS];
  logic [LW-1:0]                code_length;
  logic [kpl_pkg::TIMER_W-1:0]  mode_timer;
  logic [kpl_pkg::TONE_W-1:0]   tone;
  logic [kpl_pkg::TIMER_W-1:0]  lockout_ticks;
  logic [kpl_pkg::TONE_W-1:0]   warning_tone;
  logic [kpl_pkg::TONE_W-1:0]   unlocked_tone;
  logic [kpl_pkg::TONE_W-1:0]   success_tone;

  logic          entry_inc;
  logic [CW-1:0] entry_after;
  logic          new_inc;
  logic [CW-1:0] new_after;
  logic          match;
  logic [1:0]    entry_view;

  // counts after this tick's digit, saturating one past the store depth
  assign entry_inc   = tick.digit && (entry_count <= CW'(MAX_DIGITS));
  assign entry_after = entry_count + CW'(entry_inc);
  assign new_inc     = tick.digit && (new_count <= CW'(MAX_DIGITS));
  assign new_after   = new_count + CW'(new_inc);

  // parallel compare of the code-length prefix, seeing this tick's digit
  always_comb begin
    match      = 1'b1;
    entry_view = kpl_pkg::DIGIT_NONE;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      entry_view = (tick.digit && entry_count == CW'(i)) ? tick.dval : entry_digits[i];
      if (LW'(i) < code_length && entry_view != stored_code[i]) begin
        match = 1'b0;
      end
    end
  end

  // status to the controller
  assign sts.match      = match;
  assign sts.over       = entry_after > CW'(code_length);
  assign sts.new_bad    = (new_after == '0) || (new_after > CW'(MAX_DIGITS));
  assign sts.timer_zero = (mode_timer == '0);
  assign sts.timer_done = (mode_timer >= lockout_ticks);

  // buzzer tone selection
  always_comb begin
    case (cmd.tone_sel)
      kpl_pkg::TONE_WARNING:  tone_next = warning_tone;
      kpl_pkg::TONE_UNLOCKED: tone_next = unlocked_tone;
      kpl_pkg::TONE_SUCCESS:  tone_next = success_tone;
      default:                tone_next = tone;
    endcase
  end

  // entry store and count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        entry_digits[i] <= kpl_pkg::DIGIT_NONE;
      end
    end else begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (cmd.entry_clear_all) begin
          entry_digits[i] <= kpl_pkg::DIGIT_NONE;
        end else if (cmd.entry_write && entry_count == CW'(i)) begin
          entry_digits[i] <= tick.dval;
        end
      end
      if (cmd.entry_count_clr) begin
        entry_count <= '0;
      end else if (cmd.entry_write) begin
        entry_count <= entry_after;
      end
    end
  end

  // new-code store and count
  always_ff @(posedge clk) begin
    if (rst) begin
      new_count <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        new_digits[i] <= 2'd0;
      end
    end else begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (cmd.new_zero) begin
          new_digits[i] <= 2'd0;
        end else if (cmd.new_write && new_count == CW'(i)) begin
          new_digits[i] <= tick.dval;
        end
      end
      if (cmd.new_count_clr) begin
        new_count <= '0;
      end else if (cmd.new_write) begin
        new_count <= new_after;
      end
    end
  end

  // stored code; positions past the new length read zero after install
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= LW'(CODE_LEN_RESET);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_code[i] <= kpl_pkg::reset_digit(i);
      end
    end else if (cmd.install) begin
      code_length <= new_count[LW-1:0];
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_code[i] <= (CW'(i) < new_count) ? new_digits[i] : 2'd0;
      end
    end
  end

  // mode timer and buzzer tone
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_timer <= '0;
      tone       <= kpl_pkg::START_TONE_RESET;
    end else begin
      tone <= tone_next;
      case (cmd.timer_op)
        kpl_pkg::TIMER_CLEAR:   mode_timer <= '0;
        kpl_pkg::TIMER_INC:     mode_timer <= mode_timer + kpl_pkg::TIMER_W'(1);
        kpl_pkg::TIMER_RESTART: mode_timer <= kpl_pkg::TIMER_W'(1);
        default:                mode_timer <= mode_timer;
      endcase
    end
  end

  // configuration registers; the start tone is the reset value of the tone
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= kpl_pkg::LOCKOUT_RESET;
      warning_tone  <= kpl_pkg::WARNING_TONE_RESET;
      unlocked_tone <= kpl_pkg::UNLOCKED_TONE_RESET;
      success_tone  <= kpl_pkg::SUCCESS_TONE_RESET;
    end else if (cfg_valid) begin
      case (kpl_pkg::cfg_reg_t'(cfg_index))
        kpl_pkg::REG_LOCKOUT:       lockout_ticks <= cfg_data;
        kpl_pkg::REG_START_TONE:    ;
        kpl_pkg::REG_WARNING_TONE:  warning_tone  <= cfg_data[kpl_pkg::TONE_W-1:0];
        kpl_pkg::REG_UNLOCKED_TONE: unlocked_tone <= cfg_data[kpl_pkg::TONE_W-1:0];
        kpl_pkg::REG_SUCCESS_TONE:  success_tone  <= cfg_data[kpl_pkg::TONE_W-1:0];
        default:                    ;
      endcase
    end
  end

endmodule

// ===== rtl/core/keypad_passcode_lock.sv =====
// keypad_passcode_lock: top level, tick stream in, status word stream out
// depends on kpl_pkg, kpl_ctrl and kpl_datapath
//
// One input word is one millisecond tick of key events; each accepted tick
// yields exactly one status word. A tick is decided in the cycle it is
// accepted (a ten-lane parallel compare of the entry against the stored code)
// and its status word sits in the output register from the next cycle on.
// The block takes one tick per clock: s_axis_tready is high whenever the
// output register is empty or is being drained in the same cycle, so the
// rate is set by the output handshake alone. Configuration writes are
// always accepted, cfg_ready being tied high; write them only while the
// block is idle. A write to the start tone register is taken but the
// buzzer frequency after reset is always its reset value.
module keypad_passcode_lock #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] digit_pressed, [2:1] digit_value, [3] enter_pressed, [4] change_hold
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] mode, [3] buzzer_on, [18:4] buzzer_hz, [20:19] red_led,
  // [22:21] green_led, [23] blue_led, [26:24] message
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic                       step;
  kpl_pkg::tick_t             tick;
  kpl_pkg::dp_cmd_t           cmd;
  kpl_pkg::dp_sts_t           sts;
  kpl_pkg::mode_t             mode_next;
  kpl_pkg::ind_t              ind_next;
  logic [kpl_pkg::TONE_W-1:0] tone_next;

  // handshakes
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // key decode; digit code three counts as no key
  assign tick.digit = s_axis_tdata[0] && (s_axis_tdata[2:1] != kpl_pkg::DIGIT_NONE);
  assign tick.dval  = s_axis_tdata[2:1];
  assign tick.enter = s_axis_tdata[3];
  assign tick.hold  = s_axis_tdata[4];

  kpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .tick      (tick),
    .sts       (sts),
    .cmd       (cmd),
    .mode_next (mode_next),
    .ind_next  (ind_next)
  );

  kpl_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .cmd       (cmd),
    .sts       (sts),
    .tone_next (tone_next),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {5'd0, ind_next.message, ind_next.blue, ind_next.green,
                       ind_next.red, tone_next, ind_next.buz, mode_next};
    end
  end

endmodule

// ===== rtl/core/kpl_checker.sv =====
// kpl_checker: port-level checks of keypad_passcode_lock, bound to the top level
// depends on kpl_pkg and keypad_passcode_lock
module kpl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [2:0] mode_f;
  logic       buz_f;
  logic [1:0] red_f;
  logic       blue_f;
  logic [2:0] msg_f;

  assign mode_f = m_axis_tdata[2:0];
  assign buz_f  = m_axis_tdata[3];
  assign red_f  = m_axis_tdata[20:19];
  assign blue_f = m_axis_tdata[23];
  assign msg_f  = m_axis_tdata[26:24];

  // a stalled word stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // unlocked always shows the unlocked message with the buzzer on
  a_unlocked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode_f == kpl_pkg::MODE_UNLOCKED
      |-> msg_f == kpl_pkg::MSG_UNLOCKED && buz_f)
    else $error("unlocked word with wrong indicators");

  // warning keeps the incorrect message and fast red blink
  a_warning: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode_f == kpl_pkg::MODE_WARNING
      |-> msg_f == kpl_pkg::MSG_WRONG && red_f == kpl_pkg::LED_FAST)
    else $error("warning word with wrong indicators");

  // accepted change keeps the blue led and its message
  a_chok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode_f == kpl_pkg::MODE_CHOK
      |-> blue_f && msg_f == kpl_pkg::MSG_CHOK)
    else $error("change-ok word with wrong indicators");

endmodule

bind keypad_passcode_lock kpl_checker u_kpl_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// tb: self-checking bench for keypad_passcode_lock, ticks in and status words out
// holds a scoreboard class that predicts every status word and plain driver tasks
// depends on kpl_pkg and the keypad_passcode_lock rtl

// one status word, mode in the lowest bits
typedef struct packed {
  logic [2:0]  msg;
  logic        blue;
  logic [1:0]  green;
  logic [1:0]  red;
  logic [14:0] hz;
  logic        buz;
  logic [2:0]  mode;
} lock_status_t;

// lock predictor and store of expected status words
class lock_scoreboard #(int DEPTH = 10);
  logic [15:0]    lockout;
  logic [14:0]    tone_start, tone_warn, tone_unl, tone_ok;
  kpl_pkg::mode_t lmode;
  logic [1:0]     code [DEPTH];
  int             code_len;
  logic [1:0]     entry [DEPTH];
  int             entry_cnt;
  logic [1:0]     fresh [DEPTH];
  int             fresh_cnt;
  logic [15:0]    timer;
  logic [14:0]    tone;
  logic           buz, blue;
  logic [1:0]     red, green;
  logic [2:0]     msg;
  lock_status_t   pending [$];
  int             failures;
  int             shown;

  function void reset_state();
    lockout    = kpl_pkg::LOCKOUT_RESET;
    tone_start = kpl_pkg::START_TONE_RESET;
    tone_warn  = kpl_pkg::WARNING_TONE_RESET;
    tone_unl   = kpl_pkg::UNLOCKED_TONE_RESET;
    tone_ok    = kpl_pkg::SUCCESS_TONE_RESET;
    lmode      = kpl_pkg::MODE_LOCKED;
    for (int i = 0; i < DEPTH; i++) begin
      code[i]  = kpl_pkg::reset_digit(i);
      entry[i] = kpl_pkg::DIGIT_NONE;
      fresh[i] = 2'd0;
    end
    code_len  = (kpl_pkg::RESET_CODE_LEN < DEPTH) ? kpl_pkg::RESET_CODE_LEN : DEPTH;
    entry_cnt = 0;
    fresh_cnt = 0;
    timer     = '0;
    tone      = tone_start;
    buz       = 1'b0;
    red       = kpl_pkg::LED_ON;
    green     = kpl_pkg::LED_OFF;
    blue      = 1'b0;
    msg       = kpl_pkg::MSG_ENTER;
  endfunction

  function void write_reg(kpl_pkg::cfg_reg_t idx, logic [15:0] val);
    case (idx)
      kpl_pkg::REG_LOCKOUT:       lockout = val;
      kpl_pkg::REG_START_TONE:    tone_start = val[14:0];
      kpl_pkg::REG_WARNING_TONE:  tone_warn = val[14:0];
      kpl_pkg::REG_UNLOCKED_TONE: tone_unl = val[14:0];
      kpl_pkg::REG_SUCCESS_TONE:  tone_ok = val[14:0];
      default: ;
    endcase
  endfunction

  function bit is_active();
    return lmode == kpl_pkg::MODE_LOCKED || lmode == kpl_pkg::MODE_UNLOCKED ||
           lmode == kpl_pkg::MODE_CHANGE;
  endfunction

  function void clear_entry();
    for (int i = 0; i < DEPTH; i++) entry[i] = kpl_pkg::DIGIT_NONE;
  endfunction

  function void go_warning();
    lmode = kpl_pkg::MODE_WARNING;
    buz   = 1'b1;
    msg   = kpl_pkg::MSG_WRONG;
    red   = kpl_pkg::LED_FAST;
  endfunction

  function void relock();
    red   = kpl_pkg::LED_OFF;
    timer = '0;
    lmode = kpl_pkg::MODE_LOCKED;
    buz   = 1'b0;
    msg   = kpl_pkg::MSG_ENTER;
  endfunction

  // advance one tick and queue the status word it must produce
  function void note_tick(logic [7:0] w);
    logic [1:0]   dv;
    logic         dg, en, hd, ok;
    lock_status_t e;
    dv = w[2:1];
    dg = w[0] && (dv != kpl_pkg::DIGIT_NONE);
    en = w[3];
    hd = w[4];
    case (lmode)
      kpl_pkg::MODE_LOCKED: begin
        timer = '0;
        if (dg) begin
          if (entry_cnt < DEPTH) entry[entry_cnt] = dv;
          if (entry_cnt <= DEPTH) entry_cnt++;
        end
        green = kpl_pkg::LED_OFF;
        red   = kpl_pkg::LED_ON;
        if (en) begin
          ok = 1'b1;
          entry_cnt = 0;
          for (int i = 0; i < code_len && i < DEPTH; i++)
            if (entry[i] != code[i]) ok = 1'b0;
          if (ok) begin
            lmode = kpl_pkg::MODE_UNLOCKED;
            tone  = tone_unl;
            buz   = 1'b1;
            msg   = kpl_pkg::MSG_UNLOCKED;
            green = kpl_pkg::LED_SLOW;
          end else begin
            go_warning();
          end
        end
        if (entry_cnt > code_len) go_warning();
        // change hold overrides whatever happened above, except buzzer and tone
        if (hd) begin
          entry_cnt = 0;
          fresh_cnt = 0;
          clear_entry();
          msg   = kpl_pkg::MSG_SET_NEW;
          red   = kpl_pkg::LED_SLOW;
          green = kpl_pkg::LED_SLOW;
          lmode = kpl_pkg::MODE_CHANGE;
        end
      end
      kpl_pkg::MODE_WARNING: begin
        entry_cnt = 0;
        if (timer == 0) clear_entry();
        if (timer >= lockout) relock();
        timer = timer + 16'd1;
      end
      kpl_pkg::MODE_UNLOCKED: begin
        red = kpl_pkg::LED_OFF;
        if (dg || en) begin
          clear_entry();
          entry_cnt = 0;
          lmode = kpl_pkg::MODE_LOCKED;
          tone  = tone_warn;
          buz   = 1'b0;
          msg   = kpl_pkg::MSG_ENTER;
          green = kpl_pkg::LED_OFF;
        end
      end
      kpl_pkg::MODE_CHANGE: begin
        if (dg) begin
          if (fresh_cnt < DEPTH) fresh[fresh_cnt] = dv;
          if (fresh_cnt <= DEPTH) fresh_cnt++;
        end
        if (en) begin
          if (fresh_cnt == 0 || fresh_cnt > DEPTH) begin
            lmode = kpl_pkg::MODE_CHFAIL;
            buz   = 1'b1;
            msg   = kpl_pkg::MSG_CHFAIL;
            red   = kpl_pkg::LED_FAST;
            green = kpl_pkg::LED_OFF;
          end else begin
            lmode = kpl_pkg::MODE_CHOK;
            tone  = tone_ok;
            buz   = 1'b1;
            msg   = kpl_pkg::MSG_CHOK;
            green = kpl_pkg::LED_OFF;
            red   = kpl_pkg::LED_OFF;
            blue  = 1'b1;
          end
        end
      end
      kpl_pkg::MODE_CHFAIL: begin
        entry_cnt = 0;
        fresh_cnt = 0;
        if (timer == 0)
          for (int i = 0; i < DEPTH; i++) fresh[i] = 2'd0;
        if (timer >= lockout) relock();
        timer = timer + 16'd1;
      end
      default: begin
        // change succeeded: install the new code once the lockout has run out
        if (timer >= lockout) begin
          for (int i = 0; i < DEPTH; i++) code[i] = (i < fresh_cnt) ? fresh[i] : 2'd0;
          code_len  = fresh_cnt;
          fresh_cnt = 0;
          lmode = kpl_pkg::MODE_LOCKED;
          buz   = 1'b0;
          tone  = tone_warn;
          msg   = kpl_pkg::MSG_ENTER;
          blue  = 1'b0;
        end
        timer = timer + 16'd1;
      end
    endcase
    e.mode  = lmode;
    e.buz   = buz;
    e.hz    = tone;
    e.red   = red;
    e.green = green;
    e.blue  = blue;
    e.msg   = msg;
    pending.push_back(e);
  endfunction

  // compare one accepted status word with the oldest expectation
  function void check_status(logic [31:0] w);
    lock_status_t a, e;
    a = lock_status_t'(w[26:0]);
    if (pending.size() == 0) begin
      failures++;
      if (shown < 10) begin
        shown++;
        $display("unexpected status word %h", w);
      end
      return;
    end
    e = pending.pop_front();
    if (a.mode != e.mode || a.buz != e.buz || a.hz != e.hz || a.red != e.red ||
        a.green != e.green || a.blue != e.blue || a.msg != e.msg) begin
      failures++;
      if (shown < 10) begin
        shown++;
        $display("status mismatch: expected mode %0d buz %0d hz %0d red %0d green %0d",
                 e.mode, e.buz, e.hz, e.red, e.green, " blue %0d msg %0d", e.blue, e.msg);
        $display("                 actual   mode %0d buz %0d hz %0d red %0d green %0d",
                 a.mode, a.buz, a.hz, a.red, a.green, " blue %0d msg %0d", a.blue, a.msg);
      end
    end
  endfunction

  function void finish_check();
    if (pending.size() != 0) begin
      failures += pending.size();
      $display("%0d status words never arrived", pending.size());
    end
  endfunction
endclass

module tb;
  localparam int DEPTH        = 10;
  localparam int STALL_CYCLES = 200;
  localparam int IDLE_LIMIT   = 5000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  lock_scoreboard #(DEPTH) sb;
  logic [7:0] script [$];
  bit         stall_request;
  int         quiet_cycles;

  keypad_passcode_lock #(.MAX_DIGITS(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // tick word: [0] digit_pressed, [2:1] digit_value, [3] enter, [4] change hold
  function automatic logic [7:0] key(bit dp, logic [1:0] dv, bit en, bit hd);
    return {3'b000, hd, en, dv, dp};
  endfunction

  function automatic logic [7:0] idle_tick();
    return key(1'b0, 2'($urandom_range(0, 3)), 1'b0, 1'b0);
  endfunction

  function automatic logic [7:0] noise_tick();
    return 8'($urandom_range(0, 31));
  endfunction

  // push digit ticks for one code, sometimes with quiet ticks in between
  task automatic push_digits(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) script.push_back(idle_tick());
      if ($urandom_range(0, 11) == 0)
        script.push_back(key(1'b1, kpl_pkg::DIGIT_NONE, 1'b0, 1'b0));
      script.push_back(key(1'b1, 2'($urandom_range(0, 2)), 1'b0, 1'b0));
    end
  endtask

  // plan the next stretch of ticks from the mode the lock is in
  task automatic plan_ticks();
    int r, n;
    r = $urandom_range(0, 99);
    case (sb.lmode)
      kpl_pkg::MODE_LOCKED: begin
        if (r < 40) begin
          // correct code, last digit sometimes together with enter
          for (int i = 0; i < sb.code_len; i++) begin
            if ($urandom_range(0, 9) < 2) script.push_back(idle_tick());
            if (i == sb.code_len - 1 && $urandom_range(0, 3) == 0)
              script.push_back(key(1'b1, sb.code[i], 1'b1, 1'b0));
            else
              script.push_back(key(1'b1, sb.code[i], 1'b0, 1'b0));
          end
          if (script[$][3] == 1'b0) script.push_back(key(1'b0, 2'd0, 1'b1, 1'b0));
        end else if (r < 55) begin
          push_digits($urandom_range(0, sb.code_len));
          script.push_back(key(1'b0, 2'($urandom_range(0, 3)), 1'b1, 1'b0));
        end else if (r < 65) begin
          push_digits(sb.code_len + 1);
        end else if (r < 83) begin
          // new code entry
          if ($urandom_range(0, 3) == 0) push_digits($urandom_range(1, 3));
          script.push_back(key(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'b1));
          n = $urandom_range(0, 19);
          if (n == 0) n = 0;
          else if (n == 1) n = DEPTH;
          else if (n == 2) n = DEPTH + 1;
          else if (n == 3) n = DEPTH + 2;
          else n = $urandom_range(1, 5);
          push_digits(n);
          script.push_back(key(1'b0, 2'($urandom_range(0, 3)), 1'b1, 1'b0));
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) script.push_back(noise_tick());
        end
      end
      kpl_pkg::MODE_UNLOCKED: begin
        n = $urandom_range(0, 3);
        repeat (n) script.push_back(idle_tick());
        script.push_back(key(1'b1, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0));
      end
      kpl_pkg::MODE_CHANGE: begin
        push_digits($urandom_range(0, 6));
        script.push_back(key(1'b0, 2'd0, 1'b1, 1'b0));
      end
      default: begin
        if (r < 70) script.push_back(idle_tick());
        else script.push_back(noise_tick());
      end
    endcase
  endtask

  // offer ticks until enough have been taken
  task automatic send_ticks(int count, bit count_all);
    int  n, gap;
    bit  calm, act;
    logic [7:0] w;
    n = 0;
    calm = 1'b0;
    while (n < count) begin
      if (script.size() == 0) plan_ticks();
      w = script.pop_front();
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= w;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      act = sb.is_active();
      sb.note_tick(w);
      if (act || count_all) n++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(kpl_pkg::cfg_reg_t idx, logic [15:0] val, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] lock_t, logic [15:0] start_t,
                              logic [15:0] warn_t, logic [15:0] unl_t, logic [15:0] ok_t);
    put_reg(kpl_pkg::REG_LOCKOUT, lock_t, 1'b0);
    put_reg(kpl_pkg::REG_START_TONE, start_t, 1'b0);
    put_reg(kpl_pkg::REG_WARNING_TONE, warn_t, 1'b0);
    put_reg(kpl_pkg::REG_UNLOCKED_TONE, unl_t, 1'b0);
    put_reg(kpl_pkg::REG_SUCCESS_TONE, ok_t, 1'b1);
  endtask

  // result side: random ready gaps plus one long hold-off on request
  initial begin
    int  gap;
    bit  calm;
    m_axis_tready <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (stall_request) gap = STALL_CYCLES;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        stall_request = 1'b0;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_status(m_axis_tdata);
    end
  end

  // watchdog on cycles with no word moving on any channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    sb = new;
    sb.reset_state();
    stall_request = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short lockout, tones at the edges of their range and past it
    program_regs(16'd2, 16'h7FFF, 16'd20000, 16'd0, 16'hFFFF);

    // directed: factory code with enter on the last digit, then relock by enter
    script.push_back(key(1'b0, 2'd0, 1'b0, 1'b0));
    script.push_back(key(1'b1, 2'd1, 1'b0, 1'b0));
    script.push_back(key(1'b1, 2'd2, 1'b0, 1'b0));
    script.push_back(key(1'b1, 2'd0, 1'b0, 1'b0));
    script.push_back(key(1'b1, 2'd1, 1'b0, 1'b0));
    script.push_back(key(1'b1, 2'd1, 1'b1, 1'b0));
    // digit value three is no key, so the lock stays open
    script.push_back(key(1'b1, kpl_pkg::DIGIT_NONE, 1'b0, 1'b0));
    script.push_back(key(1'b0, 2'd2, 1'b1, 1'b0));
    // wrong code, wait out the warning
    script.push_back(key(1'b1, 2'd2, 1'b0, 1'b0));
    script.push_back(key(1'b0, 2'd0, 1'b1, 1'b0));
    repeat (3) script.push_back(key(1'b0, 2'd3, 1'b0, 1'b0));
    // digit, enter and hold in one tick: hold wins
    script.push_back(key(1'b1, 2'd0, 1'b1, 1'b1));
    script.push_back(key(1'b1, 2'd0, 1'b0, 1'b0));
    script.push_back(key(1'b1, kpl_pkg::DIGIT_NONE, 1'b0, 1'b0));
    script.push_back(key(1'b0, 2'd0, 1'b1, 1'b0));
    repeat (3) script.push_back(key(1'b0, 2'd0, 1'b0, 1'b0));
    // one-digit code now installed
    script.push_back(key(1'b1, 2'd0, 1'b1, 1'b0));
    script.push_back(key(1'b0, 2'd0, 1'b1, 1'b0));
    // empty new code fails
    script.push_back(key(1'b0, 2'd0, 1'b0, 1'b1));
    script.push_back(key(1'b0, 2'd0, 1'b1, 1'b0));
    repeat (3) script.push_back(key(1'b0, 2'd1, 1'b0, 1'b0));
    // too many digits for the code length
    script.push_back(key(1'b1, 2'd2, 1'b0, 1'b0));
    script.push_back(key(1'b1, 2'd1, 1'b0, 1'b0));
    repeat (3) script.push_back(key(1'b0, 2'd2, 1'b0, 1'b0));
    send_ticks(script.size(), 1'b1);

    send_ticks(450, 1'b0);
    wait_drained();

    // lockout of one, with the result side held off for a while
    program_regs(16'd1, 16'd0, 16'hFFFF, 16'd20000, 16'd0);
    stall_request = 1'b1;
    send_ticks(450, 1'b0);
    wait_drained();

    // longest lockout: warnings do not expire within this phase
    program_regs(16'hFFFF, 16'd20000, 16'($urandom_range(0, 20000)),
                 16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20000)));
    send_ticks(250, 1'b1);
    wait_drained();

    // back to a short lockout, possibly in the middle of a warning
    program_regs(16'($urandom_range(3, 6)), 16'($urandom_range(0, 20000)),
                 16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20000)),
                 16'($urandom_range(0, 20000)));
    send_ticks(280, 1'b0);
    wait_drained();

    repeat (10) @(posedge clk);
    sb.finish_check();
    if (sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kpl_pkg.sv
rtl/core/kpl_ctrl.sv
rtl/core/kpl_datapath.sv
rtl/core/keypad_passcode_lock.sv
rtl/core/kpl_checker.sv
bench/tb.sv
